// File: hdl/bpa_pkg.sv
// Shared types and constants for the two-pool bitmap page allocator.
// Holds the field widths, the status codes and the sequencer states.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package bpa_pkg;

  localparam int PAGE_W         = 52;
  localparam int CNT_W          = 11;
  localparam int CFG_IDX_W      = 2;
  localparam int DEF_POOL_PAGES = 1024;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_BASE  = 2'd0,
    REG_KERNEL_COUNT = 2'd1,
    REG_USER_BASE    = 2'd2,
    REG_USER_COUNT   = 2'd3
  } cfg_reg_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_PAGE = 2'd1,
    ST_BAD     = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_FLOOK,
    S_FCHK,
    S_FCLR
  } state_t;

endpackage

// File: hdl/bpa_map.sv
// Usage-bit store for both pools: one bit per page, pool select as the top address bit.
// One write port and one registered read port. Uses bpa_pkg.
`timescale 1ns / 1ps

module bpa_map import bpa_pkg::*; #(
  parameter int POOL_PAGES = DEF_POOL_PAGES
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(POOL_PAGES):0]    waddr,
  input  logic                           wdata,
  input  logic [$clog2(POOL_PAGES):0]    raddr,
  output logic                           rdata
);

  localparam int AW = $clog2(POOL_PAGES) + 1;

  logic mem [2**AW];
  logic rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/bitmap_page_allocator.sv
// Top level of the two-pool bitmap first-fit page allocator: sequencer and registers.
// Instantiates bpa_map and imports bpa_pkg.
//
//   Channel | Direction | Handshake           | Payload
//   in_     | input     | in_valid/in_ready   | action, pool_sel, panic_on_fail, count, page
//   out_    | output    | out_valid/out_ready | first_page, status, panic
//   cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
// An allocation scans the pool up to the end of the first free run (a failed scan of a
// non-empty pool reads every page) and then marks the run, one usage bit per cycle through
// the single read and write port of the map. A free first checks that the run is wholly in
// use and then clears it. Requests that are ignored are answered the cycle after the
// transfer. After reset a clearing pass writes every map entry, during which no input is
// taken. A waiting result blocks new input until it has been taken.
`timescale 1ns / 1ps

module bitmap_page_allocator import bpa_pkg::*; #(
  parameter int POOL_PAGES = DEF_POOL_PAGES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_action,
  input  logic                 in_pool_sel,
  input  logic                 in_panic_on_fail,
  input  logic [CNT_W-1:0]     in_page_count,
  input  logic [PAGE_W-1:0]    in_page_number,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PAGE_W-1:0]    out_first_page,
  output logic [1:0]           out_status,
  output logic                 out_panic,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PAGE_W-1:0]    cfg_wdata
);

  localparam int IW = $clog2(POOL_PAGES);
  localparam int AW = IW + 1;
  localparam int SW = $clog2(POOL_PAGES + 1);
  localparam int XW = ((SW > CNT_W) ? SW : CNT_W) + 1;

  // Configuration registers.
  logic [PAGE_W-1:0] kbase_r, ubase_r;
  logic [CNT_W-1:0]  kcnt_r, ucnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kbase_r <= '0;
      kcnt_r  <= '0;
      ubase_r <= '0;
      ucnt_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KERNEL_BASE:  kbase_r <= cfg_wdata;
        REG_KERNEL_COUNT: kcnt_r  <= cfg_wdata[CNT_W-1:0];
        REG_USER_BASE:    ubase_r <= cfg_wdata;
        REG_USER_COUNT:   ucnt_r  <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Pool sizes, clamped to the map capacity.
  logic [SW-1:0] ksize, usize;
  assign ksize = (XW'(kcnt_r) > XW'(POOL_PAGES)) ? SW'(POOL_PAGES) : SW'(kcnt_r);
  assign usize = (XW'(ucnt_r) > XW'(POOL_PAGES)) ? SW'(POOL_PAGES) : SW'(ucnt_r);

  // Sequencer and datapath registers.
  state_t            state_r, state_nxt;
  logic              pool_r, pool_nxt;
  logic              panic_req_r, panic_req_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  run_r, run_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [PAGE_W-1:0] base_r, base_nxt;
  logic [SW-1:0]     size_r, size_nxt;
  logic [XW-1:0]     pos_r, pos_nxt;
  logic [XW-1:0]     end_r, end_nxt;
  logic [IW-1:0]     start_r, start_nxt;
  logic [IW-1:0]     pidx_r, pidx_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [PAGE_W-1:0] out_first_r, out_first_nxt;
  status_t           out_status_r, out_status_nxt;
  logic              out_panic_r, out_panic_nxt;

  // Map access.
  logic          map_we, map_wdata, rbit;
  logic [AW-1:0] map_waddr, map_raddr;

  bpa_map #(.POOL_PAGES(POOL_PAGES)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (rbit)
  );

  // Condition flags shared by the next-state and datapath logic.
  logic              accept, req_ignored;
  logic [CNT_W-1:0]  run_step;
  logic              hit, scan_end, chk_bad, chk_end, wr_last, clr_last, issue;
  logic [PAGE_W-1:0] kdiff, udiff, sel_diff;
  logic              kin, uin, lookup_bad;
  logic [SW-1:0]     sel_size;
  logic [IW-1:0]     fidx;
  logic [XW-1:0]     hit_end;

  always_comb begin
    accept      = in_valid && in_ready;
    req_ignored = (in_page_count == '0) || (in_action && (in_page_number == '0));
    run_step    = rbit ? '0 : run_r + 1'b1;
    hit         = pend_r && (run_step == cnt_r);
    scan_end    = !pend_r && (pos_r >= XW'(size_r));
    chk_bad     = pend_r && !rbit;
    chk_end     = !pend_r && (pos_r >= end_r);
    wr_last     = ((pos_r + 1'b1) == end_r);
    clr_last    = &clr_r;
    issue       = ((state_r == S_SCAN) && !hit && (pos_r < XW'(size_r))) ||
                  ((state_r == S_FCHK) && !chk_bad && (pos_r < end_r));
    hit_end     = XW'(pidx_r) + 1'b1;
    // Pool lookup for a free; the kernel pool wins where the pools overlap.
    kdiff       = page_r - kbase_r;
    udiff       = page_r - ubase_r;
    kin         = (page_r >= kbase_r) && (kdiff < PAGE_W'(ksize));
    uin         = (page_r >= ubase_r) && (udiff < PAGE_W'(usize));
    sel_diff    = kin ? kdiff : udiff;
    sel_size    = kin ? ksize : usize;
    fidx        = sel_diff[IW-1:0];
    lookup_bad  = (!kin && !uin) || ((XW'(fidx) + XW'(cnt_r)) > XW'(sel_size));
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept && !req_ignored) begin
          state_nxt = in_action ? S_FLOOK : S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = S_MARK;
        end else if (scan_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_MARK:  if (wr_last) state_nxt = S_IDLE;
      S_FLOOK: state_nxt = lookup_bad ? S_IDLE : S_FCHK;
      S_FCHK: begin
        if (chk_bad) begin
          state_nxt = S_IDLE;
        end else if (chk_end) begin
          state_nxt = S_FCLR;
        end
      end
      S_FCLR:  if (wr_last) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and result loading.
  always_comb begin
    pool_nxt       = pool_r;
    panic_req_nxt  = panic_req_r;
    cnt_nxt        = cnt_r;
    run_nxt        = run_r;
    page_nxt       = page_r;
    base_nxt       = base_r;
    size_nxt       = size_r;
    pos_nxt        = pos_r;
    end_nxt        = end_r;
    start_nxt      = start_r;
    pidx_nxt       = pos_r[IW-1:0];
    pend_nxt       = issue;
    clr_nxt        = clr_r + 1'b1;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_first_nxt  = out_first_r;
    out_status_nxt = out_status_r;
    out_panic_nxt  = out_panic_r;
    if (issue) begin
      pos_nxt = pos_r + 1'b1;
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          pool_nxt      = in_pool_sel;
          panic_req_nxt = in_panic_on_fail;
          cnt_nxt       = in_page_count;
          page_nxt      = in_page_number;
          base_nxt      = in_pool_sel ? ubase_r : kbase_r;
          size_nxt      = in_pool_sel ? usize : ksize;
          pos_nxt       = '0;
          run_nxt       = '0;
          if (req_ignored) begin
            out_valid_nxt  = 1'b1;
            out_first_nxt  = '0;
            out_status_nxt = ST_IGNORED;
            out_panic_nxt  = 1'b0;
          end
        end
      end
      S_SCAN: begin
        if (pend_r) begin
          run_nxt = run_step;
        end
        if (hit) begin
          start_nxt = IW'(hit_end - XW'(cnt_r));
          pos_nxt   = hit_end - XW'(cnt_r);
          end_nxt   = hit_end;
        end else if (scan_end) begin
          out_valid_nxt  = 1'b1;
          out_first_nxt  = '0;
          out_status_nxt = ST_NO_PAGE;
          out_panic_nxt  = panic_req_r;
        end
      end
      S_MARK: begin
        pos_nxt = pos_r + 1'b1;
        if (wr_last) begin
          out_valid_nxt  = 1'b1;
          out_first_nxt  = base_r + PAGE_W'(start_r);
          out_status_nxt = ST_OK;
          out_panic_nxt  = 1'b0;
        end
      end
      S_FLOOK: begin
        pool_nxt = !kin;
        pos_nxt  = XW'(fidx);
        end_nxt  = XW'(fidx) + XW'(cnt_r);
        if (lookup_bad) begin
          out_valid_nxt  = 1'b1;
          out_first_nxt  = '0;
          out_status_nxt = ST_BAD;
          out_panic_nxt  = 1'b0;
        end
      end
      S_FCHK: begin
        if (chk_bad) begin
          out_valid_nxt  = 1'b1;
          out_first_nxt  = '0;
          out_status_nxt = ST_BAD;
          out_panic_nxt  = 1'b0;
        end else if (chk_end) begin
          pos_nxt = end_r - XW'(cnt_r);
        end
      end
      S_FCLR: begin
        pos_nxt = pos_r + 1'b1;
        if (wr_last) begin
          out_valid_nxt  = 1'b1;
          out_first_nxt  = '0;
          out_status_nxt = ST_OK;
          out_panic_nxt  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Map port control: the clearing pass and freeing write zeros, marking writes ones.
  always_comb begin
    map_we    = (state_r == S_CLEAR) || (state_r == S_MARK) || (state_r == S_FCLR);
    map_wdata = (state_r == S_MARK);
    map_waddr = (state_r == S_CLEAR) ? clr_r : {pool_r, pos_r[IW-1:0]};
    map_raddr = {pool_r, pos_r[IW-1:0]};
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pool_r       <= pool_nxt;
    panic_req_r  <= panic_req_nxt;
    cnt_r        <= cnt_nxt;
    run_r        <= run_nxt;
    page_r       <= page_nxt;
    base_r       <= base_nxt;
    size_r       <= size_nxt;
    pos_r        <= pos_nxt;
    end_r        <= end_nxt;
    start_r      <= start_nxt;
    pidx_r       <= pidx_nxt;
    out_first_r  <= out_first_nxt;
    out_status_r <= out_status_nxt;
    out_panic_r  <= out_panic_nxt;
  end

  assign in_ready       = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid      = out_valid_r;
  assign out_first_page = out_first_r;
  assign out_status     = out_status_r;
  assign out_panic      = out_panic_r;

  // A result is only shown once the sequencer has returned to idle.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid_r |-> state_r == S_IDLE)
    else $error("result shown while the sequencer is busy");

  // Panic is only raised on a failed allocation.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_panic_r) |-> out_status_r == ST_NO_PAGE)
    else $error("panic without an out-of-pages status");

  // Only a successful result carries a page number.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_first_r != '0)) |-> out_status_r == ST_OK)
    else $error("page number on a failed result");

  // No input is taken during the clearing pass.
  assert property (@(posedge clk) disable iff (!rst_n) (state_r == S_CLEAR) |-> !in_ready)
    else $error("input taken while the map is being cleared");

endmodule
